### rtl/smec_pkg.sv
// Shared types, character codes and element class codes of the SMILES element counter.
package smec_pkg;

    localparam int CHAR_W     = 8;
    localparam int ELEM_W     = 4;
    localparam int OUT_CNT_W  = 16;
    localparam int NUM_TYPES  = 11;

    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [ELEM_W-1:0]    elem_t;
    typedef logic [OUT_CNT_W-1:0] out_cnt_t;

    // Element classes, in the order they are reported.
    localparam elem_t ELEM_C     = 4'd0;
    localparam elem_t ELEM_N     = 4'd1;
    localparam elem_t ELEM_O     = 4'd2;
    localparam elem_t ELEM_F     = 4'd3;
    localparam elem_t ELEM_P     = 4'd4;
    localparam elem_t ELEM_S     = 4'd5;
    localparam elem_t ELEM_CL    = 4'd6;
    localparam elem_t ELEM_BR    = 4'd7;
    localparam elem_t ELEM_I     = 4'd8;
    localparam elem_t ELEM_BORON = 4'd9;
    localparam elem_t ELEM_OTHER = 4'd10;
    localparam elem_t ELEM_LAST  = 4'd10;
    localparam elem_t ELEM_NONE  = 4'd15;

    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;
    localparam char_t CH_DIGIT_0 = 8'h30;
    localparam char_t CH_DIGIT_9 = 8'h39;
    localparam char_t CH_UPPER_B = 8'h42;
    localparam char_t CH_UPPER_C = 8'h43;
    localparam char_t CH_UPPER_F = 8'h46;
    localparam char_t CH_UPPER_I = 8'h49;
    localparam char_t CH_UPPER_N = 8'h4E;
    localparam char_t CH_UPPER_O = 8'h4F;
    localparam char_t CH_UPPER_P = 8'h50;
    localparam char_t CH_UPPER_S = 8'h53;
    localparam char_t CH_LOWER_C = 8'h63;
    localparam char_t CH_LOWER_L = 8'h6C;
    localparam char_t CH_LOWER_N = 8'h6E;
    localparam char_t CH_LOWER_O = 8'h6F;
    localparam char_t CH_LOWER_P = 8'h70;
    localparam char_t CH_LOWER_R = 8'h72;
    localparam char_t CH_LOWER_S = 8'h73;
    localparam char_t CH_OPEN    = 8'h5B;
    localparam char_t CH_CLOSE   = 8'h5D;
    localparam char_t CH_SPACE   = 8'h20;
    localparam char_t CH_TAB     = 8'h09;

    function automatic elem_t elem_of(input char_t c);
        elem_t e;
        unique case (c)
            CH_UPPER_C, CH_LOWER_C: e = ELEM_C;
            CH_UPPER_N, CH_LOWER_N: e = ELEM_N;
            CH_UPPER_O, CH_LOWER_O: e = ELEM_O;
            CH_UPPER_F:             e = ELEM_F;
            CH_UPPER_P, CH_LOWER_P: e = ELEM_P;
            CH_UPPER_S, CH_LOWER_S: e = ELEM_S;
            CH_UPPER_I:             e = ELEM_I;
            CH_UPPER_B:             e = ELEM_BORON;
            default:                e = ELEM_NONE;
        endcase
        return e;
    endfunction

    function automatic logic is_upper(input char_t c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_lower(input char_t c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

### rtl/smec_in_if.sv
// Byte channel into the SMILES element counter.
interface smec_in_if import smec_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t char_code;
    logic  final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

### rtl/smec_out_if.sv
// Count result channel out of the SMILES element counter.
interface smec_out_if import smec_pkg::*; ();
    logic     valid;
    logic     ready;
    elem_t    element_index;
    out_cnt_t element_count;
    out_cnt_t atom_total;
    logic     parse_ok;
    logic     last_result;

    modport source (output valid, output element_index, output element_count,
                    output atom_total, output parse_ok, output last_result, input ready);
    modport sink   (input valid, input element_index, input element_count,
                    input atom_total, input parse_ok, input last_result, output ready);
endinterface

### rtl/smiles_element_counter.sv
// SMILES element counter: byte parser, per-class counters and result drain bank.
//
//   channel    dir   payload                                         per item
//   byte_in    in    char_code, final_char                           one string byte
//   count_out  out   element_index, element_count, atom_total,       one element class
//                    parse_ok, last_result
//
// Bytes are taken one per cycle into an input register, except while a final byte is held
// there; the parser updates its mode and counters from that register. The final byte of a
// string copies the counts into a bank that drains eleven items, one per cycle while
// count_out is ready, and clears the parser, so the next string can stream in meanwhile.
// A final byte waits in the input register only while the bank still holds the
// previous string's results; the bank reloads in the cycle its last item is taken.
// Reset clears the parser, the counters and both valid flags at once.
module smiles_element_counter
    import smec_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    smec_in_if.sink    byte_in,
    smec_out_if.source count_out
);

    typedef enum logic [2:0] {
        MODE_OUT,
        MODE_PEND_C,
        MODE_PEND_B,
        MODE_BR_DIG,
        MODE_BR_SYM,
        MODE_BR_NEED,
        MODE_BR_SKIP,
        MODE_DONE
    } mode_t;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_add(input cnt_t v, input logic [1:0] n);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, v} + {{(COUNT_WIDTH-1){1'b0}}, n};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic out_cnt_t to_out(input cnt_t v);
        logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, v};
        return ext[OUT_CNT_W-1:0];
    endfunction

    // Input register.
    logic  in_valid_reg;
    char_t in_char_reg;
    logic  in_final_reg;

    // Parser state.
    mode_t mode_reg, mode_next;
    char_t held_reg, held_next;
    logic  failed_reg, failed_next;
    cnt_t  cnt_reg  [NUM_TYPES];
    cnt_t  cnt_next [NUM_TYPES];
    cnt_t  total_reg, total_next;

    // Result bank.
    logic     busy_reg;
    elem_t    idx_reg;
    cnt_t     snap_reg [NUM_TYPES];
    out_cnt_t snap_total_reg;
    logic     snap_ok_reg;

    logic       out_take;
    logic       bank_free;
    logic       proc;
    logic       load;
    logic       run_out;
    logic       run_skip;
    logic       fin_failed;
    logic [1:0] tot_inc;
    elem_t      ev_a, ev_b, ev_c;
    elem_t      held_elem;
    elem_t      char_elem;
    logic [1:0] bump_n [NUM_TYPES];

    assign out_take  = busy_reg && count_out.ready;
    assign bank_free = !busy_reg || (out_take && (idx_reg == ELEM_LAST));
    assign proc      = in_valid_reg && (!in_final_reg || bank_free);
    assign load      = proc && in_final_reg;

    assign byte_in.ready = !in_valid_reg || proc;

    assign held_elem = elem_of(held_reg);
    assign char_elem = elem_of(in_char_reg);

    // Each byte can raise at most three class events: a pending or bracket symbol,
    // a plain atom (also one after a pending C or B), and the end-of-string completion.
    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        failed_next = failed_reg;
        ev_a        = ELEM_NONE;
        ev_b        = ELEM_NONE;
        ev_c        = ELEM_NONE;
        tot_inc     = 2'd0;
        run_out     = 1'b0;
        run_skip    = 1'b0;
        fin_failed  = 1'b0;

        unique case (mode_reg)
            MODE_OUT:
            begin
                run_out = 1'b1;
            end
            MODE_PEND_C:
            begin
                mode_next = MODE_OUT;
                tot_inc   = 2'd1;
                if (in_char_reg == CH_LOWER_L)
                begin
                    ev_a = ELEM_CL;
                end
                else
                begin
                    ev_a    = ELEM_C;
                    run_out = 1'b1;
                end
            end
            MODE_PEND_B:
            begin
                mode_next = MODE_OUT;
                tot_inc   = 2'd1;
                if (in_char_reg == CH_LOWER_R)
                begin
                    ev_a = ELEM_BR;
                end
                else
                begin
                    ev_a    = ELEM_BORON;
                    run_out = 1'b1;
                end
            end
            MODE_BR_DIG:
            begin
                if (!is_digit(in_char_reg))
                begin
                    if (is_upper(in_char_reg)
                        || (is_lower(in_char_reg) && (char_elem != ELEM_NONE)))
                    begin
                        held_next = in_char_reg;
                        mode_next = MODE_BR_SYM;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                        mode_next   = MODE_DONE;
                    end
                end
            end
            MODE_BR_SYM:
            begin
                if (is_upper(held_reg) && is_lower(in_char_reg))
                begin
                    if ((held_reg == CH_UPPER_C) && (in_char_reg == CH_LOWER_L))
                    begin
                        ev_a      = ELEM_CL;
                        mode_next = MODE_BR_NEED;
                    end
                    else if (held_reg == CH_UPPER_B)
                    begin
                        // B with another lowercase letter is a token of no class.
                        if (in_char_reg == CH_LOWER_R)
                        begin
                            ev_a = ELEM_BR;
                        end
                        mode_next = MODE_BR_NEED;
                    end
                    else
                    begin
                        ev_a      = ELEM_OTHER;
                        mode_next = MODE_BR_SKIP;
                    end
                end
                else
                begin
                    ev_a      = (held_elem != ELEM_NONE) ? held_elem : ELEM_OTHER;
                    mode_next = MODE_BR_SKIP;
                    run_skip  = 1'b1;
                end
            end
            MODE_BR_NEED:
            begin
                mode_next = MODE_BR_SKIP;
                run_skip  = 1'b1;
            end
            MODE_BR_SKIP:
            begin
                run_skip = 1'b1;
            end
            MODE_DONE:
            begin
            end
        endcase

        if (run_out)
        begin
            priority if (is_blank(in_char_reg))
            begin
                mode_next = MODE_DONE;
            end
            else if (in_char_reg == CH_UPPER_C)
            begin
                mode_next = MODE_PEND_C;
            end
            else if (in_char_reg == CH_UPPER_B)
            begin
                mode_next = MODE_PEND_B;
            end
            else if (in_char_reg == CH_OPEN)
            begin
                mode_next = MODE_BR_DIG;
            end
            else if (in_char_reg == CH_CLOSE)
            begin
                failed_next = 1'b1;
                mode_next   = MODE_DONE;
            end
            else if (char_elem != ELEM_NONE)
            begin
                ev_b    = char_elem;
                tot_inc = tot_inc + 2'd1;
            end
            else
            begin
            end
        end

        if (run_skip)
        begin
            if (in_char_reg == CH_CLOSE)
            begin
                tot_inc   = tot_inc + 2'd1;
                mode_next = MODE_OUT;
            end
            else if (is_blank(in_char_reg))
            begin
                failed_next = 1'b1;
                mode_next   = MODE_DONE;
            end
        end

        // End of string: settle whatever the last byte left open.
        fin_failed = failed_next;
        if (in_final_reg)
        begin
            unique case (mode_next)
                MODE_PEND_C:
                begin
                    ev_c    = ELEM_C;
                    tot_inc = tot_inc + 2'd1;
                end
                MODE_PEND_B:
                begin
                    ev_c    = ELEM_BORON;
                    tot_inc = tot_inc + 2'd1;
                end
                MODE_BR_DIG, MODE_BR_SYM, MODE_BR_NEED:
                begin
                    fin_failed = 1'b1;
                end
                MODE_BR_SKIP:
                begin
                    tot_inc = tot_inc + 2'd1;
                end
                default:
                begin
                end
            endcase
        end

        for (int i = 0; i < NUM_TYPES; i++)
        begin
            bump_n[i]   = 2'((ev_a == elem_t'(i))) + 2'((ev_b == elem_t'(i)))
                        + 2'((ev_c == elem_t'(i)));
            cnt_next[i] = sat_add(cnt_reg[i], bump_n[i]);
        end
        total_next = sat_add(total_reg, tot_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_char_reg    <= '0;
            in_final_reg   <= 1'b0;
            mode_reg       <= MODE_OUT;
            held_reg       <= '0;
            failed_reg     <= 1'b0;
            total_reg      <= '0;
            busy_reg       <= 1'b0;
            idx_reg        <= ELEM_C;
            snap_total_reg <= '0;
            snap_ok_reg    <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                cnt_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
        end
        else
        begin
            if (byte_in.valid && byte_in.ready)
            begin
                in_valid_reg <= 1'b1;
                in_char_reg  <= byte_in.char_code;
                in_final_reg <= byte_in.final_char;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (load)
            begin
                mode_reg   <= MODE_OUT;
                held_reg   <= '0;
                failed_reg <= 1'b0;
                total_reg  <= '0;
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    cnt_reg[i] <= '0;
                end
            end
            else if (proc)
            begin
                mode_reg   <= mode_next;
                held_reg   <= held_next;
                failed_reg <= failed_next;
                total_reg  <= total_next;
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end

            // The bank shifts down as items are taken, so slot 0 is always on the port.
            if (load)
            begin
                busy_reg       <= 1'b1;
                idx_reg        <= ELEM_C;
                snap_total_reg <= fin_failed ? '0 : to_out(total_next);
                snap_ok_reg    <= !fin_failed;
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    snap_reg[i] <= cnt_next[i];
                end
            end
            else if (out_take)
            begin
                if (idx_reg == ELEM_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + elem_t'(1);
                for (int i = 0; i < NUM_TYPES - 1; i++)
                begin
                    snap_reg[i] <= snap_reg[i+1];
                end
            end
        end
    end

    assign count_out.valid         = busy_reg;
    assign count_out.element_index = idx_reg;
    assign count_out.element_count = to_out(snap_reg[0]);
    assign count_out.atom_total    = snap_total_reg;
    assign count_out.parse_ok      = snap_ok_reg;
    assign count_out.last_result   = (idx_reg == ELEM_LAST);

endmodule
